// File: sv/tpq_pkg.sv
// Shared constants and controller/datapath command and status types for the touch qualifier.
`default_nettype none

package tpq_pkg;

	localparam int RAW_W   = 16;
	localparam int CODE_W  = 12;
	localparam int CFG_W   = 12;
	localparam int CNT_W   = 8;
	localparam int READS_W = 9;
	localparam int ACC_W   = 32;
	localparam int STEP_W  = 5;
	localparam int POS_W   = 13;

	localparam logic [CODE_W-1:0]  CODE_MAX    = 12'hFFF;
	localparam logic [ACC_W-1:0]   ROUND_HALF  = 32'd2047;
	localparam int                 RT_SHIFT    = 12;
	localparam logic [STEP_W-1:0]  DIV_LAST    = 5'd31;

	localparam logic [CNT_W-1:0]   IGNORE_RST  = 8'd0;
	localparam logic [CNT_W-1:0]   PER_RST     = 8'd1;
	localparam logic [CODE_W-1:0]  PLATE_RST   = 12'd180;

	typedef enum logic [1:0] {
		REG_IGNORE = 2'd0,
		REG_PER    = 2'd1,
		REG_PLATE  = 2'd2,
		REG_NONE   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic load;       // capture input item
		logic mul;        // run the shared multiplier into the accumulator
		logic mul_plate;  // second product: accumulator times plate factor
		logic div_step;   // one restoring divide step
		logic retire;     // close the item, update window and stylus state
	} dp_cmd_t;

	typedef struct packed {
		logic div_last;
		logic emit;
	} dp_sts_t;

endpackage

`default_nettype wire

// File: sv/tpq_if.sv
// Handshake interfaces for touch input items and qualified result items.
`default_nettype none

interface tpq_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] raw_y;
	logic [15:0] raw_x;
	logic [15:0] raw_z1;
	logic [15:0] raw_z2;

	modport source (output valid, raw_y, raw_x, raw_z1, raw_z2, input ready);
	modport sink   (input valid, raw_y, raw_x, raw_z1, raw_z2, output ready);
endinterface

interface tpq_out_if;
	logic               valid;
	logic               ready;
	logic signed [12:0] pos_x;
	logic signed [12:0] pos_y;
	logic        [11:0] pressure;
	logic               touch_valid;
	logic               was_down;

	modport source (output valid, pos_x, pos_y, pressure, touch_valid, was_down,
		input ready);
	modport sink   (input valid, pos_x, pos_y, pressure, touch_valid, was_down,
		output ready);
endinterface

`default_nettype wire

// File: sv/touch_pressure_qualifier.sv
// Each input item is loaded, run through two products and the divide, then retired, when its
// result item is registered. A new input item is taken only once the last one has retired.
// The 32-step restoring divider follows the two products on the shared 32x12 multiplier; a
// result still held by the sink holds the item at retirement. An item whose window is not yet
// used up and whose pressure overflows 12 bits gives no result. Reset clears the state machine,
// read count, stylus state and output valid; loads register defaults; there is no clearing pass.
`default_nettype none

module touch_pressure_qualifier import tpq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	tpq_in_if.sink           sample,
	tpq_out_if.source        result
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	tpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tpq_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.raw_y       (sample.raw_y),
		.raw_x       (sample.raw_x),
		.raw_z1      (sample.raw_z1),
		.raw_z2      (sample.raw_z2),
		.cmd         (cmd),
		.sts         (sts),
		.pos_x       (result.pos_x),
		.pos_y       (result.pos_y),
		.pressure    (result.pressure),
		.touch_valid (result.touch_valid),
		.was_down    (result.was_down)
	);

endmodule

`default_nettype wire

// File: sv/tpq_dp.sv
// Datapath: config registers, shared multiplier, restoring divider, window and result registers.
`default_nettype none

module tpq_dp import tpq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic [1:0]               cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic [RAW_W-1:0]         raw_y,
	input  logic [RAW_W-1:0]         raw_x,
	input  logic [RAW_W-1:0]         raw_z1,
	input  logic [RAW_W-1:0]         raw_z2,
	input  dp_cmd_t                  cmd,
	output dp_sts_t                  sts,
	output logic signed [POS_W-1:0]  pos_x,
	output logic signed [POS_W-1:0]  pos_y,
	output logic [CODE_W-1:0]        pressure,
	output logic                     touch_valid,
	output logic                     was_down
);

	logic [CNT_W-1:0]   ignore_q, per_q;
	logic [CODE_W-1:0]  plate_q;
	logic [CODE_W-1:0]  y_q, x_q, z1_q, z2_q;
	logic [ACC_W-1:0]   acc_q;
	logic [CODE_W-1:0]  rem_q;
	logic [STEP_W-1:0]  step_q;
	logic [READS_W-1:0] reads_q;
	logic               down_q;
	logic [POS_W-1:0]   pos_x_q, pos_y_q;
	logic [CODE_W-1:0]  pressure_q;
	logic               touch_valid_q, was_down_q;

	logic [CODE_W-1:0]  x_code;
	logic [ACC_W-1:0]   diff, mul_a, mul_p;
	logic [CODE_W-1:0]  mul_b;
	logic [CODE_W:0]    rem_shift;
	logic               q_bit;
	logic [ACC_W-1:0]   rt_sum;
	logic [ACC_W-RT_SHIFT-1:0] rt;
	logic               rt_big, valid;
	logic [READS_W-1:0] reads_next, window_raw, window;

	// An x code at full scale means no contact on the x plate.
	assign x_code = (raw_x[RAW_W-1:4] == CODE_MAX) ? '0 : raw_x[RAW_W-1:4];

	assign diff  = {{(ACC_W-CODE_W){1'b0}}, z2_q} - {{(ACC_W-CODE_W){1'b0}}, z1_q};
	assign mul_a = cmd.mul_plate ? acc_q : diff;
	assign mul_b = cmd.mul_plate ? plate_q : x_q;
	assign mul_p = mul_a * {{(ACC_W-CODE_W){1'b0}}, mul_b};

	assign rem_shift = {rem_q, acc_q[ACC_W-1]};
	assign q_bit     = (rem_shift >= {1'b0, z1_q});

	assign rt_sum = acc_q + ROUND_HALF;
	assign rt     = (x_q == '0 || z1_q == '0) ? '0 : rt_sum[ACC_W-1:RT_SHIFT];
	assign rt_big = |rt[ACC_W-RT_SHIFT-1:CODE_W];
	assign valid  = !rt_big && (rt != '0);

	assign reads_next = reads_q + 9'd1;
	assign window_raw = {1'b0, ignore_q} + {1'b0, per_q};
	assign window     = (window_raw == '0) ? 9'd1 : window_raw;

	assign sts.div_last = (step_q == DIV_LAST);
	assign sts.emit     = !rt_big || (reads_next >= window);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ignore_q <= IGNORE_RST;
			per_q    <= PER_RST;
			plate_q  <= PLATE_RST;
		end else if (cfg_write) begin
			unique case (reg_idx_t'(cfg_index))
				REG_IGNORE: ignore_q <= cfg_data[CNT_W-1:0];
				REG_PER:    per_q    <= cfg_data[CNT_W-1:0];
				REG_PLATE:  plate_q  <= cfg_data[CODE_W-1:0];
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			y_q    <= raw_y[RAW_W-1:4];
			x_q    <= x_code;
			z1_q   <= raw_z1[RAW_W-1:4];
			z2_q   <= raw_z2[RAW_W-1:4];
			rem_q  <= '0;
			step_q <= '0;
		end else if (cmd.mul) begin
			acc_q <= mul_p;
		end else if (cmd.div_step) begin
			rem_q  <= q_bit ? CODE_W'(rem_shift - {1'b0, z1_q}) : rem_shift[CODE_W-1:0];
			acc_q  <= {acc_q[ACC_W-2:0], q_bit};
			step_q <= step_q + 5'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reads_q <= '0;
			down_q  <= 1'b0;
		end else if (cmd.retire) begin
			reads_q <= sts.emit ? '0 : reads_next;
			if (sts.emit) begin
				down_q <= valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.retire && sts.emit) begin
			was_down_q    <= down_q;
			touch_valid_q <= valid;
			pos_x_q       <= valid ? {1'b0, x_q} : '1;
			pos_y_q       <= valid ? {1'b0, y_q} : '1;
			pressure_q    <= valid ? rt[CODE_W-1:0] : '0;
		end
	end

	assign pos_x       = pos_x_q;
	assign pos_y       = pos_y_q;
	assign pressure    = pressure_q;
	assign touch_valid = touch_valid_q;
	assign was_down    = was_down_q;

endmodule

`default_nettype wire

// File: sv/tpq_ctrl.sv
// Controller: sequences load, two products, the divide and retirement; owns the handshakes.
`default_nettype none

module tpq_ctrl import tpq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL1 = 5'b00010,
		ST_MUL2 = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL1;
				end
			end
			ST_MUL1: begin
				cmd.mul = 1'b1;
				state_d = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul       = 1'b1;
				cmd.mul_plate = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				// hold while a result is due and the output register is still full
				if (!sts.emit || out_free) begin
					cmd.retire = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.retire && sts.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire
